// ===== design/sorted_table_range_search_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted table range search: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_RANGE_SEARCH_CORE_DEFINES_SVH
`define SORTED_TABLE_RANGE_SEARCH_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STRS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/strs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table range search: package
// Sizes, word types, item codes and the probe midpoint helper.
// ----------------------------------------------------------------------------
package strs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    localparam int PRICE_W     = 32;
    localparam int ENTRY_IDX_W = 10;
    localparam int CFG_W       = 11;
    localparam int FIRST_W     = 10;
    localparam int COUNT_W     = 11;

    typedef logic [IDX_W-1:0]       t_addr;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [PRICE_W-1:0]     t_price;
    typedef logic [FIRST_W-1:0]     t_first;
    typedef logic [COUNT_W-1:0]     t_count;
    typedef logic [CFG_W-1:0]       t_cfg;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Midpoint of the half-open window [left, rend), rend > left.
    function automatic t_cnt mid_of(input t_cnt left, input t_cnt rend);
        t_cnt span;
        span   = rend - left - t_cnt'(1);
        mid_of = left + (span >> 1);
    endfunction

endpackage

// ===== design/strs_ram.sv =====
// ----------------------------------------------------------------------------
// Sorted table range search: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module strs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sorted_table_range_search_core.sv =====
// ----------------------------------------------------------------------------
// Sorted table range search core
// Price table with two binary searches for an inclusive price range.
// ----------------------------------------------------------------------------
// A word with i_kind low loads one price into the table in the cycle it is
// accepted, and busy stays low, so loads may stream one per cycle. A word
// with i_kind high runs a range query over the first entries_in_use
// entries (capped at the table depth): a lower-bound search for the first
// price at or above i_min_price, then an upper-bound search for the last
// price at or below i_max_price. Both searches probe the single table
// read port in turn: busy covers the lower issue state, p1 lower probes,
// the upper issue state, p2 upper probes and the finish state, where p1
// and p2 are the probe counts of the two searches (each at most
// floor(log2(n)) + 1); the upper states are skipped when nothing reaches
// the minimum, and an empty table has no probes at all. The result
// word is shown for exactly one cycle with o_done high, in the first cycle
// that busy is low again; the receiver cannot stall it, so capture it then.
// A new word may be accepted in that same cycle. Write entries_in_use only
// while busy is low. The table has no reset: load every entry a query may
// probe before querying.
// ----------------------------------------------------------------------------
module sorted_table_range_search_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        i_start,
    input  logic        i_kind,
    input  logic [9:0]  i_entry_index,
    input  logic [31:0] i_entry_price,
    input  logic [31:0] i_min_price,
    input  logic [31:0] i_max_price,
    input  logic [10:0] i_result_limit,
    output logic        o_busy,
    output logic        o_done,
    output logic [9:0]  o_first_index,
    output logic [10:0] o_match_count
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LB_ISSUE,
        ST_LB_PROBE,
        ST_UB_ISSUE,
        ST_UB_PROBE,
        ST_FINISH
    } t_state;

    // control
    t_state                r_state, n_state;
    strs_pkg::t_cfg        r_entries_in_use;
    logic                  r_done, n_done;
    logic                  r_lb_ok, n_lb_ok;
    logic                  r_ub_ok, n_ub_ok;

    // search window and payload
    strs_pkg::t_cnt        r_left, n_left;
    strs_pkg::t_cnt        r_rend, n_rend;
    strs_pkg::t_cnt        r_len, n_len;
    strs_pkg::t_addr       r_mid, n_mid;
    strs_pkg::t_addr       r_lb, n_lb;
    strs_pkg::t_addr       r_ub, n_ub;
    strs_pkg::t_price      r_min, n_min;
    strs_pkg::t_price      r_max, n_max;
    strs_pkg::t_count      r_limit, n_limit;
    strs_pkg::t_first      r_first, n_first;
    strs_pkg::t_count      r_count, n_count;

    logic                  accept;
    logic                  load_we;
    strs_pkg::t_cnt        tab_len;
    strs_pkg::t_price      rdata;
    strs_pkg::t_price      cmp_a, cmp_b;
    logic                  hit;
    logic                  go_left;
    strs_pkg::t_cnt        mid_ext;
    strs_pkg::t_cnt        step_left, step_rend;
    strs_pkg::t_cnt        raddr_cnt;
    strs_pkg::t_cnt        span;
    logic                  matched;
    strs_pkg::t_cnt        count_raw;

    assign accept = i_start && (r_state == ST_IDLE);

    // Drop loads that land beyond the table.
    assign load_we = accept && (i_kind == strs_pkg::KIND_LOAD)
                     && (32'(i_entry_index) < 32'(strs_pkg::TABLE_DEPTH));

    // Cap an oversized entry count at the table depth.
    assign tab_len = (32'(r_entries_in_use) > 32'(strs_pkg::TABLE_DEPTH))
                     ? strs_pkg::t_cnt'(strs_pkg::TABLE_DEPTH)
                     : strs_pkg::t_cnt'(r_entries_in_use);

    strs_ram #(
        .WIDTH (strs_pkg::PRICE_W),
        .DEPTH (strs_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (strs_pkg::t_addr'(i_entry_index)),
        .i_wdata (i_entry_price),
        .i_raddr (raddr_cnt[strs_pkg::IDX_W-1:0]),
        .o_rdata (rdata)
    );

    // Shared comparator: lower search asks price >= min, upper search
    // asks price <= max; both become "not (a < b)".
    always_comb begin
        if (r_state == ST_UB_PROBE) begin
            cmp_a = r_max;
            cmp_b = rdata;
        end else begin
            cmp_a = rdata;
            cmp_b = r_min;
        end
    end

    assign hit = !(cmp_a < cmp_b);

    // A lower-search hit narrows leftwards, an upper-search hit rightwards.
    assign go_left = (r_state == ST_UB_PROBE) ? !hit : hit;
    assign mid_ext = strs_pkg::t_cnt'(r_mid);

    always_comb begin
        if (go_left) begin
            step_left = r_left;
            step_rend = mid_ext;
        end else begin
            step_left = mid_ext + strs_pkg::t_cnt'(1);
            step_rend = r_rend;
        end
    end

    // Match span and clamp for the finish cycle.
    assign matched   = r_ub_ok && (r_ub >= r_lb);
    assign span      = strs_pkg::t_cnt'(r_ub) - strs_pkg::t_cnt'(r_lb)
                       + strs_pkg::t_cnt'(1);
    assign count_raw = matched ? span : '0;

    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_lb_ok   = r_lb_ok;
        n_ub_ok   = r_ub_ok;
        n_left    = r_left;
        n_rend    = r_rend;
        n_len     = r_len;
        n_mid     = r_mid;
        n_lb      = r_lb;
        n_ub      = r_ub;
        n_min     = r_min;
        n_max     = r_max;
        n_limit   = r_limit;
        n_first   = r_first;
        n_count   = r_count;
        raddr_cnt = strs_pkg::mid_of(r_left, r_rend);

        case (r_state)
            ST_IDLE: begin
                if (accept && (i_kind == strs_pkg::KIND_QUERY)) begin
                    n_left  = '0;
                    n_rend  = tab_len;
                    n_len   = tab_len;
                    n_lb_ok = 1'b0;
                    n_ub_ok = 1'b0;
                    n_min   = i_min_price;
                    n_max   = i_max_price;
                    n_limit = i_result_limit;
                    n_state = ST_LB_ISSUE;
                end
            end
            ST_LB_ISSUE, ST_UB_ISSUE: begin
                // An empty window here only happens on an empty table.
                if (r_left < r_rend) begin
                    n_mid   = raddr_cnt[strs_pkg::IDX_W-1:0];
                    n_state = (r_state == ST_LB_ISSUE) ? ST_LB_PROBE : ST_UB_PROBE;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_LB_PROBE, ST_UB_PROBE: begin
                if (hit && (r_state == ST_LB_PROBE)) begin
                    n_lb    = r_mid;
                    n_lb_ok = 1'b1;
                end
                if (hit && (r_state == ST_UB_PROBE)) begin
                    n_ub    = r_mid;
                    n_ub_ok = 1'b1;
                end
                n_left    = step_left;
                n_rend    = step_rend;
                // Issue the next probe straight from the narrowed window.
                raddr_cnt = strs_pkg::mid_of(step_left, step_rend);
                if (step_left < step_rend) begin
                    n_mid = raddr_cnt[strs_pkg::IDX_W-1:0];
                end else if ((r_state == ST_LB_PROBE) && (hit || r_lb_ok)) begin
                    n_left  = '0;
                    n_rend  = r_len;
                    n_state = ST_UB_ISSUE;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_first = matched ? strs_pkg::t_first'(r_lb) : '0;
                if (32'(count_raw) > 32'(r_limit)) begin
                    n_count = r_limit;
                end else begin
                    n_count = strs_pkg::t_count'(count_raw);
                end
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_done           <= 1'b0;
            r_lb_ok          <= 1'b0;
            r_ub_ok          <= 1'b0;
            r_entries_in_use <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_lb_ok <= n_lb_ok;
            r_ub_ok <= n_ub_ok;
            if (i_cfg_we) begin
                r_entries_in_use <= i_cfg_wdata;
            end
        end
        r_left  <= n_left;
        r_rend  <= n_rend;
        r_len   <= n_len;
        r_mid   <= n_mid;
        r_lb    <= n_lb;
        r_ub    <= n_ub;
        r_min   <= n_min;
        r_max   <= n_max;
        r_limit <= n_limit;
        r_first <= n_first;
        r_count <= n_count;
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_first_index = r_first;
    assign o_match_count = r_count;

endmodule

// ===== design/strs_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted table range search: port checker
// Watches the top-level ports for sequencing slips.
// ----------------------------------------------------------------------------
`include "sorted_table_range_search_core_defines.svh"

module strs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       i_kind,
    input logic       o_busy,
    input logic       o_done
);

    logic query_acc;
    logic load_acc;

    assign query_acc = i_start && !o_busy && (i_kind == strs_pkg::KIND_QUERY);
    assign load_acc  = i_start && !o_busy && (i_kind == strs_pkg::KIND_LOAD);

    `STRS_ASSERT_NEXT(a_query_goes_busy, i_clk, i_rst_n, query_acc, o_busy, "query not taken")
    `STRS_ASSERT_NEXT(a_load_stays_free, i_clk, i_rst_n, load_acc, !o_busy && !o_done, "load held")
    `STRS_ASSERT_SAME(a_done_after_busy, i_clk, i_rst_n, o_done, $past(o_busy), "stray result")
    `STRS_ASSERT_SAME(a_done_frees_port, i_clk, i_rst_n, o_done, !o_busy, "busy with result")
    `STRS_ASSERT_NEXT(a_done_one_cycle, i_clk, i_rst_n, o_done, !o_done, "result repeated")

endmodule

bind sorted_table_range_search_core strs_checker u_strs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_kind  (i_kind),
    .o_busy  (o_busy),
    .o_done  (o_done)
);

// ===== bench/sorted_table_range_search_core_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted table range search: result checker
// Mirrors the price table and the entry count from the accepted words,
// predicts each range result and compares it with the block's output.
// ----------------------------------------------------------------------------
module sorted_table_range_search_core_checker
    import strs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_we,
    input  t_cfg   i_cfg_wdata,
    input  logic   i_start,
    input  logic   i_busy,
    input  logic   i_kind,
    input  t_addr  i_entry_index,
    input  t_price i_entry_price,
    input  t_price i_min_price,
    input  t_price i_max_price,
    input  t_count i_result_limit,
    input  logic   i_done,
    input  t_first i_first_index,
    input  t_count i_match_count,
    output int     o_fail_count,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_first first;
        t_count count;
    } t_range_hit;

    t_price     price_copy [TABLE_DEPTH];
    t_cfg       live_entries;
    t_range_hit hits_due [$];
    int         mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Count above the depth searches the whole table.
    function automatic int search_len();
        int n;
        n = int'(live_entries);
        return (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    endfunction

    function automatic int lowest_at_or_above(t_price lo_p);
        int lo, hi, mid, hit;
        lo  = 0;
        hi  = search_len() - 1;
        hit = -1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (price_copy[mid] >= lo_p) begin
                hit = mid;
                hi  = mid - 1;
            end else begin
                lo  = mid + 1;
            end
        end
        return hit;
    endfunction

    function automatic int highest_at_or_below(t_price hi_p);
        int lo, hi, mid, hit;
        lo  = 0;
        hi  = search_len() - 1;
        hit = -1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (price_copy[mid] <= hi_p) begin
                hit = mid;
                lo  = mid + 1;
            end else begin
                hi  = mid - 1;
            end
        end
        return hit;
    endfunction

    function automatic t_range_hit range_hit_of(t_price lo_p, t_price hi_p, t_count cap);
        int         lb, ub;
        t_range_hit r;
        r  = '0;
        lb = lowest_at_or_above(lo_p);
        if (lb >= 0) begin
            ub = highest_at_or_below(hi_p);
            if (ub >= lb) begin
                r.count = t_count'(ub - lb + 1);
                r.first = t_first'(lb);
            end
        end
        // Clamp only the count: the index survives a zero limit.
        if (r.count > cap)
            r.count = cap;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_range_hit want;
        if (!i_rst_n) begin
            live_entries = '0;
            hits_due.delete();
        end else begin
            // Retire the finished query before taking a word in the same cycle.
            if (i_done) begin
                if (hits_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: range result with none outstanding: first_index %0d match_count %0d",
                                 $time, i_first_index, i_match_count);
                end else begin
                    want = hits_due.pop_front();
                    if (want.first !== i_first_index || want.count !== i_match_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: range result mismatch: first_index exp %0d got %0d, match_count exp %0d got %0d",
                                     $time, want.first, i_first_index, want.count, i_match_count);
                    end
                end
            end
            if (i_cfg_we)
                live_entries = i_cfg_wdata;
            if (i_start && !i_busy) begin
                if (i_kind == KIND_LOAD)
                    price_copy[i_entry_index] = i_entry_price;
                else
                    hits_due.push_back(range_hit_of(i_min_price, i_max_price, i_result_limit));
            end
        end
        o_pending    <= hits_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== bench/tb_sorted_table_range_search_core.sv =====
// ----------------------------------------------------------------------------
// Sorted table range search: testbench top
// Loads price tables, sets the entry count and issues range queries with
// random gaps; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_sorted_table_range_search_core;
    timeunit 1ns;
    timeprecision 1ps;
    import strs_pkg::*;

    // A query's busy time and the sender's gaps both stay far below this
    // limit, so a silence of this length can only mean a hang.
    localparam int   STALL_LIMIT  = 1000;
    localparam int   RANDOM_WORDS = 1550;
    localparam int   TAIL_CYCLES  = 40;
    localparam t_cfg CFG_TOP      = '1;

    logic   i_clk          = 1'b0;
    logic   i_rst_n        = 1'b0;
    logic   i_cfg_we       = 1'b0;
    t_cfg   i_cfg_wdata    = '0;
    logic   i_start        = 1'b0;
    logic   i_kind         = KIND_LOAD;
    t_addr  i_entry_index  = '0;
    t_price i_entry_price  = '0;
    t_price i_min_price    = '0;
    t_price i_max_price    = '0;
    t_count i_result_limit = '0;

    logic   o_busy;
    logic   o_done;
    t_first o_first_index;
    t_count o_match_count;

    int     fail_count;
    int     pending_results;
    int     stall_cycles = 0;
    bit     timed_out    = 1'b0;

    // Prices as loaded, used to aim queries at real table values.
    t_price shadow [TABLE_DEPTH];
    int     live_n       = 0;
    int     random_words = 0;
    int     burst_left   = 0;

    always #4 i_clk = ~i_clk;

    sorted_table_range_search_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start        (i_start),
        .i_kind         (i_kind),
        .i_entry_index  (i_entry_index),
        .i_entry_price  (i_entry_price),
        .i_min_price    (i_min_price),
        .i_max_price    (i_max_price),
        .i_result_limit (i_result_limit),
        .o_busy         (o_busy),
        .o_done         (o_done),
        .o_first_index  (o_first_index),
        .o_match_count  (o_match_count)
    );

    sorted_table_range_search_core_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_kind         (i_kind),
        .i_entry_index  (i_entry_index),
        .i_entry_price  (i_entry_price),
        .i_min_price    (i_min_price),
        .i_max_price    (i_max_price),
        .i_result_limit (i_result_limit),
        .i_done         (o_done),
        .i_first_index  (o_first_index),
        .i_match_count  (o_match_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results)
    );

    // Watchdog: count cycles in which no word moves in either direction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Present one word and hold it until the block takes it. Entered and left
    // at a falling edge. Gaps are drawn per word; now and then a run of words
    // goes back to back with no gap at all.
    task automatic send_word(input logic kind, input t_addr idx, input t_price price,
                             input t_price lo_p, input t_price hi_p, input t_count cap);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start        = 1'b1;
        i_kind         = kind;
        i_entry_index  = idx;
        i_entry_price  = price;
        i_min_price    = lo_p;
        i_max_price    = hi_p;
        i_result_limit = cap;
        do @(posedge i_clk); while (o_busy);
        if (kind == KIND_LOAD)
            shadow[idx] = price;
        @(negedge i_clk);
    endtask

    // Load words carry random query fields, which the block must ignore.
    task automatic load_entry(input t_addr idx, input t_price price);
        send_word(KIND_LOAD, idx, price, $urandom(), $urandom(), t_count'($urandom()));
    endtask

    // Query words carry random load fields likewise.
    task automatic ask_range(input t_price lo_p, input t_price hi_p, input t_count cap);
        send_word(KIND_QUERY, t_addr'($urandom()), $urandom(), lo_p, hi_p, cap);
    endtask

    // Write the entry count only once the block has gone quiet: drop start,
    // wait out every outstanding query, then allow a few spare cycles.
    task automatic write_entries(input int n);
        i_start = 1'b0;
        do @(posedge i_clk); while (pending_results != 0 || o_busy);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = t_cfg'(n);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        live_n      = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    endtask

    // Mostly prices that sit in the live table, or just beside them, so the
    // searches land on boundaries; otherwise the extremes or anything at all.
    function automatic t_price pick_price();
        t_price p;
        int     k;
        if (live_n == 0)
            return $urandom();
        p = shadow[$urandom_range(0, live_n - 1)];
        k = $urandom_range(0, 9);
        case (k)
            0, 1, 2, 3: return p;
            4:          return p + 1;
            5:          return p - 1;
            6:          return '0;
            7:          return '1;
            default:    return $urandom();
        endcase
    endfunction

    task automatic random_query();
        t_price a, b, t;
        t_count cap;
        int     k;
        a = pick_price();
        b = pick_price();
        // Keep most bounds in order; let about one in five stay crossed.
        if (a > b && $urandom_range(0, 4) != 0) begin
            t = a;
            a = b;
            b = t;
        end
        k = $urandom_range(0, 9);
        case (k)
            0:       cap = '0;
            1:       cap = '1;
            2:       cap = t_count'(TABLE_DEPTH);
            3:       cap = t_count'($urandom());
            default: cap = t_count'($urandom_range(0, live_n + 2));
        endcase
        ask_range(a, b, cap);
        random_words++;
    endtask

    // Load entries 0..n-1 with ascending prices, in index order or shuffled.
    // Steps are tiny (long runs of equal prices), moderate, or wide enough to
    // sweep the whole price range; one table in eight gets a few swaps so the
    // searches also meet an unsorted table.
    task automatic fill_sorted(input int n, input bit shuffled);
        t_price          vals  [TABLE_DEPTH];
        int              order [TABLE_DEPTH];
        longint unsigned acc;
        int unsigned     step_max;
        int              mode, i, j, t;
        mode = $urandom_range(0, 2);
        case (mode)
            0:       step_max = 3;
            1:       step_max = 32'hFFFF_FFFF / n;
            default: step_max = 1000;
        endcase
        acc = (mode == 1) ? $urandom_range(0, 100) : $urandom();
        for (i = 0; i < n; i++) begin
            vals[i] = (acc > 64'hFFFF_FFFF) ? '1 : t_price'(acc);
            acc += $urandom_range(0, step_max);
            order[i] = i;
        end
        if ($urandom_range(0, 3) == 0) begin
            vals[0]     = '0;
            vals[n - 1] = '1;
        end
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                i       = $urandom_range(0, n - 1);
                j       = $urandom_range(0, n - 1);
                acc     = vals[i];
                vals[i] = vals[j];
                vals[j] = t_price'(acc);
            end
        end
        if (shuffled) begin
            for (i = n - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                t        = order[i];
                order[i] = order[j];
                order[j] = t;
            end
        end
        for (i = 0; i < n; i++) begin
            load_entry(t_addr'(order[i]), vals[order[i]]);
            random_words++;
        end
    endtask

    // Hand-picked words on a six-entry table with a run of equal prices
    // and both price extremes, and on empty and one-entry tables.
    task automatic run_directed();
        // Empty table straight out of reset.
        ask_range('0, '1, t_count'(TABLE_DEPTH));
        load_entry(0, '0);
        load_entry(1, 100);
        load_entry(2, 100);
        load_entry(3, 100);
        load_entry(4, 5000);
        load_entry(5, '1);
        write_entries(6);
        ask_range('0, '1, CFG_TOP);                   // whole table, widest limit
        ask_range(100, 100, t_count'(TABLE_DEPTH));   // run of equal prices
        ask_range(101, 4999, t_count'(TABLE_DEPTH));  // falls between entries: no match
        ask_range(5000, 100, t_count'(TABLE_DEPTH));  // crossed bounds
        ask_range('1, '1, 1);                         // top entry only
        ask_range(1, '1, '0);                         // zero limit with matches present
        ask_range(50, 150, 2);                        // count clamped by the limit
        ask_range('0, '0, t_count'(TABLE_DEPTH));     // bottom entry only
        write_entries(1);
        ask_range('0, '1, t_count'(TABLE_DEPTH));
        ask_range(1, '1, t_count'(TABLE_DEPTH));      // nothing reaches the minimum
        write_entries(0);
        ask_range('0, '1, t_count'(TABLE_DEPTH));     // empty by count
    endtask

    task automatic run_random();
        int k, n;
        // Fill the whole table once: from then on any count is safe to use,
        // the oversized ones included, since no probe can hit an unloaded entry.
        fill_sorted(TABLE_DEPTH, 1'b1);
        write_entries(TABLE_DEPTH);
        repeat (40) random_query();
        write_entries(CFG_TOP);
        repeat (20) random_query();
        write_entries($urandom_range(TABLE_DEPTH + 1, 2046));
        repeat (10) random_query();
        // Then mostly short tables, reloaded for most phases.
        while (random_words < RANDOM_WORDS) begin
            k = $urandom_range(0, 19);
            if (k < 14)
                n = $urandom_range(1, 24);
            else if (k < 17)
                n = $urandom_range(25, 160);
            else if (k < 18)
                n = 0;
            else
                n = -1;
            if (n > 0)
                fill_sorted(n, $urandom_range(0, 1));
            // A negative draw keeps the table and picks any count at all.
            write_entries((n >= 0) ? n : $urandom_range(0, 2047));
            repeat ($urandom_range(8, 30)) begin
                if (live_n > 0 && $urandom_range(0, 9) == 0) begin
                    // Overwrite a live entry between queries.
                    load_entry(t_addr'($urandom_range(0, live_n - 1)), pick_price());
                    random_words++;
                end else begin
                    random_query();
                end
            end
        end
    endtask

    initial begin
        fork
            begin
                repeat (6) @(posedge i_clk);
                @(negedge i_clk);
                i_rst_n = 1'b1;
                run_directed();
                run_random();
                // Drain: hold start low until every result is in, then linger.
                i_start = 1'b0;
                do @(posedge i_clk); while (pending_results != 0);
                repeat (TAIL_CYCLES) @(posedge i_clk);
            end
            begin
                wait (stall_cycles >= STALL_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && fail_count == 0 && pending_results == 0)
            $display("** sorted_table_range_search_core: PASSED **");
        else
            $display("** sorted_table_range_search_core: FAILED **");
        $finish;
    end

endmodule
